FILE: sv/els_pkg.sv
`default_nettype none
package els_pkg;

   localparam int FEATURES            = 16384;
   localparam int MODELS              = 10;
   localparam int SIGMOID_TABLE_DEPTH = 1024;

   localparam int MODEL_W = (MODELS > 1) ? $clog2(MODELS) : 1;
   localparam int ADDR_W  = $clog2(FEATURES * MODELS);
   localparam int IDX_W   = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int TOTAL_W = 16 + ((MODELS > 1) ? $clog2(MODELS) : 1);

   // reciprocal for the divide by MODELS, floor(2^RECIP_SHIFT / MODELS)
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'((64'd1 << RECIP_SHIFT) / MODELS);

   // request codes
   localparam logic [1:0] REQ_WR_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_WR_ICEPT  = 2'd1;
   localparam logic [1:0] REQ_FEATURE   = 2'd2;
   localparam logic [1:0] REQ_END       = 2'd3;

   // response status codes
   localparam logic [1:0] ST_ACCEPTED    = 2'd0;
   localparam logic [1:0] ST_SCORE       = 2'd1;
   localparam logic [1:0] ST_BAD_FEATURE = 2'd2;

   typedef struct packed {
      logic               latch;
      logic               decode;
      logic               wr_weight;
      logic               wr_icept;
      logic               rd_weight;
      logic               end_step;
      logic               div_a;
      logic               div_b;
      logic               load_rsp;
      logic [MODEL_W-1:0] idx;
   } els_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       feat_ok;
      logic       model_ok;
      logic       rsp_busy;
   } els_stat_type;

   typedef logic [15:0] sig_rom_type [SIGMOID_TABLE_DEPTH];

   // shift-subtract divide, used only while the table is built
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^(-t) in Q30, t in Q16 up to 8.0: series for e^(-t/8), then three squarings
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0]        term;
      logic [63:0]        e;
      logic signed [63:0] acc;
      term = 64'd1 << 30;
      acc  = signed'(term);
      for (int k = 1; k < 16; k++) begin
         term = udiv64(term * t, 64'(k) << 19);
         if (k % 2 == 1) acc = acc - signed'(term);
         else acc = acc + signed'(term);
      end
      if (acc < 0) acc = '0;
      e = unsigned'(acc);
      for (int s = 0; s < 3; s++) begin
         e = (e * e + (64'd1 << 29)) >> 30;
      end
      return e;
   endfunction

   function automatic sig_rom_type build_rom();
      sig_rom_type        rom;
      logic signed [63:0] c;
      logic [63:0]        t;
      logic [63:0]        e;
      logic [63:0]        d;
      logic [63:0]        p;
      for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
         c = -64'sd524288 + signed'((64'(2 * i + 1) << 19) / SIGMOID_TABLE_DEPTH);
         t = (c < 0) ? unsigned'(-c) : unsigned'(c);
         if (t > 64'd524288) t = 64'd524288;
         e = exp_neg_q30(t);
         d = (64'd1 << 30) + e;
         if (c >= 0) p = udiv64((64'd1 << 46) + (d >> 1), d);
         else p = udiv64((e << 16) + (d >> 1), d);
         if (p > 64'd65535) p = 64'd65535;
         rom[i] = p[15:0];
      end
      return rom;
   endfunction

   localparam sig_rom_type SIG_ROM = build_rom();

endpackage
`default_nettype wire

FILE: sv/els_dpath.sv
`default_nettype none
module els_dpath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire els_pkg::els_cmd_type cmd,
   output els_pkg::els_stat_type stat,
   input  wire  [1:0]           req_type,
   input  wire  [14:0]          req_feature_number,
   input  wire  [3:0]           req_model_number,
   input  wire  signed [15:0]   req_coeff_value,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_avg_score
);
   import els_pkg::*;

   // latched transaction
   logic [1:0]         type_ff;
   logic [14:0]        feat_ff;
   logic [3:0]         model_ff;
   logic signed [15:0] coeff_ff;

   logic [ADDR_W-1:0]  base_ff;
   logic [1:0]         status_ff;
   logic [15:0]        score_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] q0_ff;

   logic signed [15:0] weight_mem [FEATURES * MODELS];
   logic signed [15:0] rd_data_ff;
   logic signed [15:0] icept_ff [MODELS];
   logic signed [31:0] sum_ff [MODELS];

   logic               acc_pend_ff;
   logic               end_pend_ff;
   logic               rom_pend_ff;
   logic [MODEL_W-1:0] pipe_idx_ff;
   logic [IDX_W-1:0]   rom_idx_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [15:0]        rsp_score_ff;

   logic               feat_ok;
   logic               model_ok;
   logic [ADDR_W-1:0]  feat_m1;
   logic [ADDR_W-1:0]  mem_addr;
   logic signed [31:0] sum_rd;
   logic signed [32:0] acc_sum;
   logic signed [31:0] acc_sat;
   logic signed [32:0] x_full;
   logic signed [16:0] x_clamp;
   logic [15:0]        x_biased;
   logic [31:0]        x_scaled;
   logic [TOTAL_W+RECIP_SHIFT:0] recip_prod;
   logic [TOTAL_W+4:0] q0_times;
   logic [TOTAL_W+4:0] remainder;

   assign feat_ok  = (feat_ff != 15'd0) && (17'(feat_ff) <= 17'(FEATURES));
   assign model_ok = 5'(model_ff) < 5'(MODELS);
   assign feat_m1  = ADDR_W'(feat_ff) - ADDR_W'(1);

   assign stat.kind     = type_ff;
   assign stat.feat_ok  = feat_ok;
   assign stat.model_ok = model_ok;
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   // one address for the weight memory: write target or per-model read
   assign mem_addr = cmd.wr_weight ? base_ff + ADDR_W'(model_ff) : base_ff + ADDR_W'(cmd.idx);

   // saturating accumulate of the fetched weight
   assign sum_rd  = sum_ff[pipe_idx_ff];
   assign acc_sum = 33'(sum_rd) + 33'(rd_data_ff);
   always_comb begin
      if (acc_sum > 33'sd2147483647) acc_sat = 32'sh7fffffff;
      else if (acc_sum < -33'sd2147483648) acc_sat = 32'sh80000000;
      else acc_sat = acc_sum[31:0];
   end

   // sum plus intercept, clamp to Q4.12 range, scale to a table index
   assign x_full = 33'(sum_rd) + 33'(icept_ff[pipe_idx_ff]);
   always_comb begin
      if (x_full > 33'sd32767) x_clamp = 17'sd32767;
      else if (x_full < -33'sd32768) x_clamp = -17'sd32768;
      else x_clamp = x_full[16:0];
   end
   assign x_biased = x_clamp[15:0] ^ 16'h8000;
   assign x_scaled = 32'(x_biased) * 32'(SIGMOID_TABLE_DEPTH);

   // divide by the model count: reciprocal multiply then one correction
   assign recip_prod = (TOTAL_W + RECIP_SHIFT + 1)'(total_ff) * (TOTAL_W + RECIP_SHIFT + 1)'(RECIP);
   assign q0_times   = (TOTAL_W + 5)'(q0_ff) * (TOTAL_W + 5)'(MODELS);
   assign remainder  = (TOTAL_W + 5)'(total_ff) - q0_times;

   // transaction capture, decode and score registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff  <= req_type;
         feat_ff  <= req_feature_number;
         model_ff <= req_model_number;
         coeff_ff <= req_coeff_value;
      end
      if (cmd.decode) begin
         base_ff  <= ADDR_W'(feat_m1 * ADDR_W'(MODELS));
         score_ff <= '0;
         total_ff <= '0;
         if ((type_ff == REQ_WR_WEIGHT || type_ff == REQ_FEATURE) && !feat_ok)
            status_ff <= ST_BAD_FEATURE;
         else if (type_ff == REQ_END) status_ff <= ST_SCORE;
         else status_ff <= ST_ACCEPTED;
      end
      if (rom_pend_ff) total_ff <= total_ff + TOTAL_W'(SIG_ROM[rom_idx_ff]);
      if (cmd.div_a) q0_ff <= TOTAL_W'(recip_prod >> RECIP_SHIFT);
      if (cmd.div_b) begin
         if (remainder >= (TOTAL_W + 5)'(MODELS)) score_ff <= 16'(q0_ff + TOTAL_W'(1));
         else score_ff <= 16'(q0_ff);
      end
      if (cmd.end_step || cmd.rd_weight) pipe_idx_ff <= cmd.idx;
      if (end_pend_ff) rom_idx_ff <= IDX_W'(x_scaled >> 16);
      if (cmd.wr_icept) icept_ff[model_ff[MODEL_W-1:0]] <= coeff_ff;
   end

   // weight memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_weight) weight_mem[mem_addr] <= coeff_ff;
      rd_data_ff <= weight_mem[mem_addr];
   end

   // pipeline control and model sums
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_pend_ff <= 1'b0;
         end_pend_ff <= 1'b0;
         rom_pend_ff <= 1'b0;
         for (int m = 0; m < MODELS; m++) sum_ff[m] <= '0;
      end else begin
         acc_pend_ff <= cmd.rd_weight;
         end_pend_ff <= cmd.end_step;
         rom_pend_ff <= end_pend_ff;
         if (acc_pend_ff) sum_ff[pipe_idx_ff] <= acc_sat;
         else if (end_pend_ff) sum_ff[pipe_idx_ff] <= '0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_score_ff  <= score_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_avg_score = rsp_score_ff;

endmodule
`default_nettype wire

FILE: sv/els_ctrl.sv
`default_nettype none
module els_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire els_pkg::els_stat_type stat,
   output els_pkg::els_cmd_type  cmd
);
   import els_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_WRITE, S_FEAT, S_FDRAIN, S_END,
      S_E1, S_E2, S_DIV1, S_DIV2, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [MODEL_W-1:0] cnt_ff, cnt_in;
   logic               last;

   assign last      = cnt_ff == MODEL_W'(MODELS - 1);
   assign req_ready = state_ff == S_IDLE;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.idx       = cnt_ff;
      cmd.latch     = req_valid && state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            cnt_in     = '0;
            case (stat.kind)
               REQ_WR_WEIGHT: state_in = S_WRITE;
               REQ_WR_ICEPT: begin
                  cmd.wr_icept = stat.model_ok;
                  state_in     = S_RESP;
               end
               REQ_FEATURE: state_in = stat.feat_ok ? S_FEAT : S_RESP;
               default: state_in = S_END;
            endcase
         end
         S_WRITE: begin
            cmd.wr_weight = stat.feat_ok && stat.model_ok;
            state_in      = S_RESP;
         end
         S_FEAT: begin
            cmd.rd_weight = 1'b1;
            cnt_in        = cnt_ff + MODEL_W'(1);
            if (last) state_in = S_FDRAIN;
         end
         S_FDRAIN: state_in = S_RESP;
         S_END: begin
            cmd.end_step = 1'b1;
            cnt_in       = cnt_ff + MODEL_W'(1);
            if (last) state_in = S_E1;
         end
         S_E1: state_in = S_E2;
         S_E2: state_in = S_DIV1;
         S_DIV1: begin
            cmd.div_a = 1'b1;
            state_in  = S_DIV2;
         end
         S_DIV2: begin
            cmd.div_b = 1'b1;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/ensemble_logistic_scorer_top.sv
// channel   | direction | handshake             | payload
// req_*     | in        | req_valid / req_ready | type, feature_number, model_number, coeff_value
// rsp_*     | out       | rsp_valid / rsp_ready | status, avg_score
//
// one transaction at a time; after the accepting cycle each request passes the decode state,
// then its own states (a write, a read per model and a drain, or an end step per model, waits
// and a divide), then the response load; the next transaction is taken as the response shows
// the single weight memory read port and the one sum adder visit one model per cycle
// synchronous active-high reset clears model sums and control; stores stay unwritten
// a stalled response holds in the output register; the next response load waits for it
`default_nettype none
module ensemble_logistic_scorer_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [1:0]         req_type,
   input  wire  [14:0]        req_feature_number,
   input  wire  [3:0]         req_model_number,
   input  wire  signed [15:0] req_coeff_value,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_avg_score
);
   import els_pkg::*;

   els_cmd_type  cmd;
   els_stat_type stat;

   els_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   els_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_type           (req_type),
      .req_feature_number (req_feature_number),
      .req_model_number   (req_model_number),
      .req_coeff_value    (req_coeff_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_avg_score      (rsp_avg_score)
   );

endmodule
`default_nettype wire

FILE: sv/els_checker.sv
`default_nettype none
module els_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_status,
   input wire [15:0] rsp_avg_score
);
   import els_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_avg_score))
      else $error("response changed while stalled");

   // only defined status codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_ACCEPTED || rsp_status == ST_SCORE
                    || rsp_status == ST_BAD_FEATURE)
      else $error("undefined status code");

   // score is zero unless a score is reported
   a_score_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_SCORE |-> rsp_avg_score == 16'd0)
      else $error("nonzero score on non-score response");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

endmodule

bind ensemble_logistic_scorer_top els_checker u_els_checker (.*);
`default_nettype wire
